// File: rtl/core/ews_pkg.sv
// Shared types, constants and register codes for the echo window sampler.
// No dependencies; used by every module under rtl/core.
package ews_pkg;

    localparam int NUM_SENSORS = 4;
    localparam int COUNT_W     = 6;
    localparam int PERIOD_W    = 8;
    localparam int CFG_DATA_W  = 8;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 32;

    typedef logic [COUNT_W-1:0]                   t_count;
    typedef logic [PERIOD_W-1:0]                  t_period;
    typedef logic [NUM_SENSORS-1:0][COUNT_W-1:0]  t_counts;

    // Register indices on the configuration channel
    localparam logic CFG_PERIOD = 1'b0;
    localparam logic CFG_LENGTH = 1'b1;

    // Word kinds carried in tuser
    localparam logic MODE_TRIGGER = 1'b0;
    localparam logic MODE_SAMPLE  = 1'b1;

    localparam t_period PERIOD_RESET  = 8'd10;
    localparam t_count  LENGTH_RESET  = 6'd30;
    localparam t_count  LATCHED_RESET = 6'd30;
    localparam t_count  COUNT_MAX     = 6'd63;

    // Trigger side to window side
    typedef struct packed {
        logic pin;       // trigger pin level after this word
        logic open_req;  // a pending start opens the window on this word
    } t_trig_status;

    // Window side result, next-state values for this word
    typedef struct packed {
        logic    open;
        logic    done;
        t_counts counts;
    } t_win_status;

endpackage

// File: rtl/core/ews_trigger.sv
// Trigger divider, trigger pin and pending window start.
// Depends on ews_pkg.
module ews_trigger (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic                  i_mode,
    input  ews_pkg::t_period      i_period,
    output ews_pkg::t_trig_status o_status
);

    ews_pkg::t_period r_div, n_div;
    logic             r_pin, n_pin;
    logic             r_pending, n_pending;
    logic             w_open_req;

    // Divider compare and next state on a trigger tick
    always_comb begin
        n_div      = r_div;
        n_pin      = r_pin;
        n_pending  = r_pending;
        w_open_req = 1'b0;
        if (i_accept && i_mode == ews_pkg::MODE_TRIGGER) begin
            if (r_div == i_period) begin
                n_pin     = 1'b1;
                n_div     = '0;
                n_pending = 1'b1;
            end else begin
                w_open_req = r_pending;
                n_pending  = 1'b0;
                n_pin      = 1'b0;
                n_div      = r_div + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div     <= '0;
            r_pin     <= 1'b0;
            r_pending <= 1'b0;
        end else begin
            r_div     <= n_div;
            r_pin     <= n_pin;
            r_pending <= n_pending;
        end
    end

    assign o_status.pin      = n_pin;
    assign o_status.open_req = w_open_req;

endmodule

// File: rtl/core/ews_window.sv
// Echo sampling window: sample counter, running and latched sensor counts.
// Depends on ews_pkg.
module ews_window (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic                          i_mode,
    input  logic [ews_pkg::NUM_SENSORS-1:0] i_echo,
    input  ews_pkg::t_count               i_length,
    input  ews_pkg::t_trig_status         i_trig,
    output ews_pkg::t_win_status          o_status
);

    logic             r_active, n_active;
    ews_pkg::t_count  r_cnt, n_cnt;
    ews_pkg::t_counts r_run, n_run;
    ews_pkg::t_counts r_latched, n_latched;
    logic             w_done;

    // Window open on trigger start, counting and latching on sample ticks
    always_comb begin
        n_active  = r_active;
        n_cnt     = r_cnt;
        n_run     = r_run;
        n_latched = r_latched;
        w_done    = 1'b0;
        if (i_accept && i_mode == ews_pkg::MODE_TRIGGER) begin
            if (i_trig.open_req) begin
                n_active = 1'b1;
            end
        end else if (i_accept && r_active) begin
            n_cnt = r_cnt + 6'd1;
            for (int i = 0; i < ews_pkg::NUM_SENSORS; i++) begin
                if (i_echo[i] && r_run[i] != ews_pkg::COUNT_MAX) begin
                    n_run[i] = r_run[i] + 6'd1;
                end
            end
            if (n_cnt == i_length) begin
                n_latched = n_run;
                n_run     = '0;
                n_cnt     = '0;
                n_active  = 1'b0;
                w_done    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_cnt     <= '0;
            r_run     <= '0;
            r_latched <= {ews_pkg::NUM_SENSORS{ews_pkg::LATCHED_RESET}};
        end else begin
            r_active  <= n_active;
            r_cnt     <= n_cnt;
            r_run     <= n_run;
            r_latched <= n_latched;
        end
    end

    assign o_status.open   = n_active;
    assign o_status.done   = w_done;
    assign o_status.counts = n_latched;

    // Sample counter only moves inside an open window
    a_cnt_needs_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != '0 |-> r_active)
        else $error("sample counter nonzero with window closed");

    // Running counts are cleared whenever the window is closed
    a_run_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> r_run == '0)
        else $error("running counts left over after window closed");

    // A closing sample leaves the window shut
    a_done_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> !r_active && r_cnt == '0)
        else $error("window still open after round done");

endmodule

// File: rtl/core/echo_window_sampler.sv
// A result word is valid in the cycle after its input word is accepted.
// Throughput: one word per cycle; the trigger and window state update on each
// accepted word and the output register takes a new word whenever it is empty
// or being drained. Synchronous active-low reset clears all state except the
// output payload, setting latched counts to 30, period to 10 and window length to 30. Depends on ews_pkg.
module echo_window_sampler (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input word stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [ews_pkg::S_TDATA_W-1:0]  i_s_tdata,  // front, left, right, down echo, 0 pad
    input  logic                           i_s_tuser,  // mode
    // Result word stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [ews_pkg::M_TDATA_W-1:0]  o_m_tdata,  // trigger_level, window_open,
                                                       // round_done, front, left, right,
                                                       // down counts, 0 pad
    // Configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_index,
    input  logic [ews_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    ews_pkg::t_period      r_period;
    ews_pkg::t_count       r_length;
    logic                  r_out_valid;
    logic [ews_pkg::M_TDATA_W-1:0] r_out_data;
    logic                  w_accept;
    ews_pkg::t_trig_status w_trig;
    ews_pkg::t_win_status  w_win;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign w_accept    = i_s_tvalid && o_s_tready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= ews_pkg::PERIOD_RESET;
            r_length <= ews_pkg::LENGTH_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ews_pkg::CFG_PERIOD: r_period <= i_cfg_data;
                ews_pkg::CFG_LENGTH: r_length <= i_cfg_data[ews_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    ews_trigger u_trigger (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_mode   (i_s_tuser),
        .i_period (r_period),
        .o_status (w_trig)
    );

    ews_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_mode   (i_s_tuser),
        .i_echo   (i_s_tdata[ews_pkg::NUM_SENSORS-1:0]),
        .i_length (r_length),
        .i_trig   (w_trig),
        .o_status (w_win)
    );

    // Output register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_out_valid <= i_s_tvalid;
        end
    end

    // Output payload, packed low field first
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= {5'd0,
                           w_win.counts[3], w_win.counts[2],
                           w_win.counts[1], w_win.counts[0],
                           w_win.done, w_win.open, w_trig.pin};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule
